### hdl/vcrp_pkg.sv
// Shared types, codes and constants of the video chip register port.
package vcrp_pkg;

	localparam int SPRITE_ENTRIES = 64;
	localparam int SPRITE_BYTES = SPRITE_ENTRIES * 4;
	localparam int SPRITE_AW = $clog2(SPRITE_BYTES);

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [13:0] PALETTE_BASE = 14'h3f00;
	localparam logic [14:0] ADDR_STEP_COL = 15'd1;
	localparam logic [14:0] ADDR_STEP_ROW = 15'd32;

	typedef enum logic [1:0] {
		MODE_WRITE  = 2'd0,
		MODE_READ   = 2'd1,
		MODE_RETURN = 2'd2,
		MODE_EVENT  = 2'd3
	} mode_t;

	localparam logic [2:0] REG_CTRL      = 3'd0;
	localparam logic [2:0] REG_MASK      = 3'd1;
	localparam logic [2:0] REG_STATUS    = 3'd2;
	localparam logic [2:0] REG_OAM_ADDR  = 3'd3;
	localparam logic [2:0] REG_OAM_DATA  = 3'd4;
	localparam logic [2:0] REG_SCROLL    = 3'd5;
	localparam logic [2:0] REG_ADDR      = 3'd6;
	localparam logic [2:0] REG_DATA      = 3'd7;

	typedef enum logic [1:0] {
		EV_CLEAR    = 2'd0,
		EV_VBLANK   = 2'd1,
		EV_SPR_HIT  = 2'd2,
		EV_OVERFLOW = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		RES_NONE      = 2'd0,
		RES_CPU       = 2'd1,
		RES_VRAM_RD   = 2'd2,
		RES_VRAM_WR   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_WR_CTRL,
		OP_WR_MASK,
		OP_WR_OAM_ADDR,
		OP_WR_OAM_DATA,
		OP_WR_SCROLL,
		OP_WR_ADDR,
		OP_WR_DATA,
		OP_RD_STATUS,
		OP_RD_OAM,
		OP_RD_DATA,
		OP_RD_OTHER,
		OP_RETURN,
		OP_EVENT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		event_t     ev;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  cpu_rdata;
		logic [13:0] vram_addr;
		logic [7:0]  vram_wdata;
		logic [7:0]  control;
		logic [7:0]  mask;
		logic [2:0]  fine_x;
		logic [14:0] scroll_tmp;
		logic [14:0] cur_addr;
	} result_t;

endpackage

### hdl/vcrp_front.sv
// Front end: classifies each incoming beat into an operation for the back end.
module vcrp_front (
	input  logic [1:0]     mode,
	input  logic [2:0]     reg_index,
	input  logic [7:0]     write_data,
	input  logic [7:0]     vram_rdata,
	input  logic [1:0]     event_code,
	output vcrp_pkg::item_t item
);
	import vcrp_pkg::*;

	op_t op;

	always_comb begin
		op = OP_NOP;
		unique case (mode_t'(mode))
			MODE_WRITE: begin
				unique case (reg_index)
					REG_CTRL:     op = OP_WR_CTRL;
					REG_MASK:     op = OP_WR_MASK;
					REG_STATUS:   op = OP_NOP;
					REG_OAM_ADDR: op = OP_WR_OAM_ADDR;
					REG_OAM_DATA: op = OP_WR_OAM_DATA;
					REG_SCROLL:   op = OP_WR_SCROLL;
					REG_ADDR:     op = OP_WR_ADDR;
					REG_DATA:     op = OP_WR_DATA;
					default:      op = OP_NOP;
				endcase
			end
			MODE_READ: begin
				unique case (reg_index)
					REG_STATUS:   op = OP_RD_STATUS;
					REG_OAM_DATA: op = OP_RD_OAM;
					REG_DATA:     op = OP_RD_DATA;
					default:      op = OP_RD_OTHER;
				endcase
			end
			MODE_RETURN: op = OP_RETURN;
			MODE_EVENT:  op = OP_EVENT;
			default:     op = OP_NOP;
		endcase
	end

	assign item.op   = op;
	assign item.data = (mode_t'(mode) == MODE_RETURN) ? vram_rdata : write_data;
	assign item.ev   = event_t'(event_code);

endmodule

### hdl/vcrp_queue.sv
// Two-entry queue between the front end and the back end.
module vcrp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  vcrp_pkg::item_t   push_item,
	input  logic              pop,
	output vcrp_pkg::item_t   head,
	output vcrp_pkg::q_stat_t stat
);
	import vcrp_pkg::*;

	item_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_CW-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	assign head       = entry_q[rd_ptr_q];
	assign stat.full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

### hdl/vcrp_back.sv
// Back end: register state, sprite memory and the registered result stage.
module vcrp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  vcrp_pkg::item_t   item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output vcrp_pkg::result_t res
);
	import vcrp_pkg::*;

	logic [7:0]  ctrl_q, ctrl_d;
	logic [7:0]  mask_q, mask_d;
	logic [2:0]  status_q, status_d;
	logic [14:0] cur_q, cur_d;
	logic [14:0] tmp_q, tmp_d;
	logic [2:0]  fx_q, fx_d;
	logic        toggle_q, toggle_d;
	logic [7:0]  oam_addr_q, oam_addr_d;
	logic [7:0]  rbuf_q, rbuf_d;
	logic        pend_q, pend_d;
	logic        pal_q, pal_d;

	logic [7:0]              oam_mem [SPRITE_BYTES];
	logic [SPRITE_BYTES-1:0] oam_vld_q;
	logic [7:0]              oam_rd_q;
	logic                    oam_rd_vld_q;
	logic                    oam_we;
	logic [7:0]              oam_byte;

	logic [14:0] cur_step;
	result_t     res_d;
	logic        out_valid_q;
	result_t     res_q;

	assign q_pop    = q_valid && (!out_valid_q || out_ready);
	assign cur_step = cur_q + (ctrl_q[2] ? ADDR_STEP_ROW : ADDR_STEP_COL);
	assign oam_we   = q_pop && (item.op == OP_WR_OAM_DATA);
	// read port tracks the sprite address of the next cycle; never-written bytes read zero
	assign oam_byte = oam_rd_vld_q ? oam_rd_q : 8'h00;

	always_comb begin
		ctrl_d     = ctrl_q;
		mask_d     = mask_q;
		status_d   = status_q;
		cur_d      = cur_q;
		tmp_d      = tmp_q;
		fx_d       = fx_q;
		toggle_d   = toggle_q;
		oam_addr_d = oam_addr_q;
		rbuf_d     = rbuf_q;
		pend_d     = pend_q;
		pal_d      = pal_q;
		res_d.kind       = RES_NONE;
		res_d.cpu_rdata  = '0;
		res_d.vram_addr  = '0;
		res_d.vram_wdata = '0;
		if (q_pop) begin
			unique case (item.op)
				OP_NOP: ;
				OP_WR_CTRL: begin
					ctrl_d = item.data;
					tmp_d  = {tmp_q[14:12], item.data[1:0], tmp_q[9:0]};
				end
				OP_WR_MASK:     mask_d = item.data;
				OP_WR_OAM_ADDR: oam_addr_d = item.data;
				OP_WR_OAM_DATA: oam_addr_d = oam_addr_q + 8'd1;
				OP_WR_SCROLL: begin
					if (!toggle_q) begin
						tmp_d = {tmp_q[14:5], item.data[7:3]};
						fx_d  = item.data[2:0];
					end else begin
						tmp_d = {item.data[2:0], tmp_q[11:10], item.data[7:3], tmp_q[4:0]};
					end
					toggle_d = !toggle_q;
				end
				OP_WR_ADDR: begin
					if (!toggle_q) begin
						tmp_d = {1'b0, item.data[5:0], tmp_q[7:0]};
					end else begin
						tmp_d = {tmp_q[14:8], item.data};
						cur_d = {tmp_q[14:8], item.data};
					end
					toggle_d = !toggle_q;
				end
				OP_WR_DATA: begin
					res_d.kind       = RES_VRAM_WR;
					res_d.vram_addr  = cur_q[13:0];
					res_d.vram_wdata = item.data;
					cur_d            = cur_step;
				end
				OP_RD_STATUS: begin
					res_d.kind      = RES_CPU;
					res_d.cpu_rdata = {status_q, 5'b0};
					status_d        = {1'b0, status_q[1:0]};
					toggle_d        = 1'b0;
				end
				OP_RD_OAM: begin
					res_d.kind      = RES_CPU;
					res_d.cpu_rdata = oam_byte;
				end
				OP_RD_DATA: begin
					res_d.kind      = RES_VRAM_RD;
					res_d.vram_addr = cur_q[13:0];
					pend_d          = 1'b1;
					pal_d           = (cur_q[13:0] >= PALETTE_BASE);
					cur_d           = cur_step;
				end
				OP_RD_OTHER: res_d.kind = RES_CPU;
				OP_RETURN: begin
					if (pend_q) begin
						res_d.kind      = RES_CPU;
						res_d.cpu_rdata = pal_q ? item.data : rbuf_q;
						rbuf_d          = item.data;
						pend_d          = 1'b0;
						pal_d           = 1'b0;
					end
				end
				OP_EVENT: begin
					unique case (item.ev)
						EV_CLEAR:    status_d = 3'b000;
						EV_VBLANK:   status_d = status_q | 3'b100;
						EV_SPR_HIT:  status_d = status_q | 3'b010;
						EV_OVERFLOW: status_d = status_q | 3'b001;
						default:     status_d = status_q;
					endcase
				end
				default: ;
			endcase
		end
		res_d.control    = ctrl_d;
		res_d.mask       = mask_d;
		res_d.fine_x     = fx_d;
		res_d.scroll_tmp = tmp_d;
		res_d.cur_addr   = cur_d;
	end

	// write at the current address, read at the next one: they never collide
	always_ff @(posedge clk) begin
		if (oam_we)
			oam_mem[oam_addr_q[SPRITE_AW-1:0]] <= item.data;
		oam_rd_q <= oam_mem[oam_addr_d[SPRITE_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q       <= '0;
			mask_q       <= '0;
			status_q     <= '0;
			cur_q        <= '0;
			tmp_q        <= '0;
			fx_q         <= '0;
			toggle_q     <= 1'b0;
			oam_addr_q   <= '0;
			rbuf_q       <= '0;
			pend_q       <= 1'b0;
			pal_q        <= 1'b0;
			oam_vld_q    <= '0;
			oam_rd_vld_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			ctrl_q       <= ctrl_d;
			mask_q       <= mask_d;
			status_q     <= status_d;
			cur_q        <= cur_d;
			tmp_q        <= tmp_d;
			fx_q         <= fx_d;
			toggle_q     <= toggle_d;
			oam_addr_q   <= oam_addr_d;
			rbuf_q       <= rbuf_d;
			pend_q       <= pend_d;
			pal_q        <= pal_d;
			if (oam_we)
				oam_vld_q[oam_addr_q[SPRITE_AW-1:0]] <= 1'b1;
			oam_rd_vld_q <= oam_vld_q[oam_addr_d[SPRITE_AW-1:0]];
			if (q_pop)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

### hdl/video_chip_register_port.sv
// Top level of the video chip register port: front end, queue, back end.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_ready  | mode, reg_index, write_data, vram_rdata,
//          |           |                      | event_code
//  out     | output    | out_valid / out_ready| result_kind, cpu_rdata, vram_addr, vram_wdata,
//          |           |                      | control_bits, mask_bits, fine_scroll_x,
//          |           |                      | temp_address, current_address
//
// One beat per cycle sustained while out_ready stays high; a beat passes the queue, then
// the result register, which offers its result and holds it until out_ready takes it.
// Every beat gives one result.
// The two-entry queue absorbs output stalls; in_ready drops only when it is full.
// Reset clears the register state, the queue pointers and the sprite memory valid bits,
// so in_ready is high once reset is released; queue entries and results are not reset.
module video_chip_register_port (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [2:0]  reg_index,
	input  logic [7:0]  write_data,
	input  logic [7:0]  vram_rdata,
	input  logic [1:0]  event_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [7:0]  cpu_rdata,
	output logic [13:0] vram_addr,
	output logic [7:0]  vram_wdata,
	output logic [7:0]  control_bits,
	output logic [7:0]  mask_bits,
	output logic [2:0]  fine_scroll_x,
	output logic [14:0] temp_address,
	output logic [14:0] current_address
);
	import vcrp_pkg::*;

	item_t   front_item;
	item_t   q_head;
	q_stat_t q_stat;
	logic    q_push;
	logic    q_pop;
	result_t res;

	assign in_ready = !q_stat.full;
	assign q_push   = in_valid && in_ready;

	vcrp_front u_front (
		.mode       (mode),
		.reg_index  (reg_index),
		.write_data (write_data),
		.vram_rdata (vram_rdata),
		.event_code (event_code),
		.item       (front_item)
	);

	vcrp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (front_item),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	vcrp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (!q_stat.empty),
		.item      (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign result_kind     = res.kind;
	assign cpu_rdata       = res.cpu_rdata;
	assign vram_addr       = res.vram_addr;
	assign vram_wdata      = res.vram_wdata;
	assign control_bits    = res.control;
	assign mask_bits       = res.mask;
	assign fine_scroll_x   = res.fine_x;
	assign temp_address    = res.scroll_tmp;
	assign current_address = res.cur_addr;

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> !q_stat.empty)
		else $error("accepted beat did not land in the queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("back end popped an empty queue");

	a_cpu_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != RES_CPU |-> cpu_rdata == 8'h00)
		else $error("processor data set on a non-read result");

	a_vram_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == RES_NONE || result_kind == RES_CPU)
		|-> vram_addr == 14'h0 && vram_wdata == 8'h00)
		else $error("video memory fields set without a request");

endmodule

### verif/register_port_checker.sv
// Response predictor and scoreboard for the video chip register port.
module register_port_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [2:0]  reg_index,
	input  logic [7:0]  write_data,
	input  logic [7:0]  vram_rdata,
	input  logic [1:0]  event_code,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  result_kind,
	input  logic [7:0]  cpu_rdata,
	input  logic [13:0] vram_addr,
	input  logic [7:0]  vram_wdata,
	input  logic [7:0]  control_bits,
	input  logic [7:0]  mask_bits,
	input  logic [2:0]  fine_scroll_x,
	input  logic [14:0] temp_address,
	input  logic [14:0] current_address,
	output int          failures,
	output int          pending_results
);
	timeunit 1ns;
	timeprecision 1ps;
	import vcrp_pkg::*;

	// shadow copy of the register file
	logic [7:0]  ctrl_q;
	logic [7:0]  mask_q;
	logic [2:0]  flags_q;       // vblank, sprite hit, overflow
	logic [14:0] cur_q;
	logic [14:0] tmp_q;
	logic [2:0]  fine_x_q;
	logic        toggle_q;
	logic [7:0]  oam_ptr;
	logic [7:0]  oam_bytes [SPRITE_BYTES];
	logic [7:0]  rbuf_q;
	logic        rd_pending_q;
	logic        rd_palette_q;

	result_t expected_results[$];

	function automatic result_t port_response(mode_t md, logic [2:0] ri, logic [7:0] wd,
			logic [7:0] rd, event_t ev);
		result_t r;
		logic [14:0] stride;
		r = '0;
		r.kind = RES_NONE;
		stride = ctrl_q[2] ? ADDR_STEP_ROW : ADDR_STEP_COL;
		case (md)
			MODE_WRITE: begin
				case (ri)
					REG_CTRL: begin
						ctrl_q = wd;
						tmp_q[11:10] = wd[1:0];
					end
					REG_MASK: mask_q = wd;
					REG_OAM_ADDR: oam_ptr = wd;
					REG_OAM_DATA: begin
						oam_bytes[oam_ptr] = wd;
						oam_ptr = oam_ptr + 8'd1;
					end
					REG_SCROLL: begin
						if (!toggle_q) begin
							tmp_q[4:0] = wd[7:3];
							fine_x_q = wd[2:0];
						end else begin
							tmp_q[9:5] = wd[7:3];
							tmp_q[14:12] = wd[2:0];
						end
						toggle_q = ~toggle_q;
					end
					REG_ADDR: begin
						if (!toggle_q) begin
							tmp_q[13:8] = wd[5:0];
							tmp_q[14] = 1'b0;
						end else begin
							tmp_q[7:0] = wd;
							cur_q = tmp_q;
						end
						toggle_q = ~toggle_q;
					end
					REG_DATA: begin
						r.kind = RES_VRAM_WR;
						r.vram_addr = cur_q[13:0];
						r.vram_wdata = wd;
						cur_q = cur_q + stride;
					end
					default: ;
				endcase
			end
			MODE_READ: begin
				if (ri == REG_DATA) begin
					// a new data read replaces any one still waiting for its return
					r.kind = RES_VRAM_RD;
					r.vram_addr = cur_q[13:0];
					rd_pending_q = 1'b1;
					rd_palette_q = (cur_q[13:0] >= PALETTE_BASE);
					cur_q = cur_q + stride;
				end else begin
					r.kind = RES_CPU;
					if (ri == REG_STATUS) begin
						r.cpu_rdata = {flags_q, 5'b0};
						flags_q[2] = 1'b0;
						toggle_q = 1'b0;
					end else if (ri == REG_OAM_DATA) begin
						r.cpu_rdata = oam_bytes[oam_ptr];
					end
				end
			end
			MODE_RETURN: begin
				if (rd_pending_q) begin
					r.kind = RES_CPU;
					r.cpu_rdata = rd_palette_q ? rd : rbuf_q;
					rbuf_q = rd;
					rd_pending_q = 1'b0;
					rd_palette_q = 1'b0;
				end
			end
			default: begin
				case (ev)
					EV_CLEAR:    flags_q = 3'b000;
					EV_VBLANK:   flags_q[2] = 1'b1;
					EV_SPR_HIT:  flags_q[1] = 1'b1;
					EV_OVERFLOW: flags_q[0] = 1'b1;
				endcase
			end
		endcase
		r.control = ctrl_q;
		r.mask = mask_q;
		r.fine_x = fine_x_q;
		r.scroll_tmp = tmp_q;
		r.cur_addr = cur_q;
		return r;
	endfunction

	task automatic check_field(string name, logic [14:0] want, logic [14:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			ctrl_q = '0;
			mask_q = '0;
			flags_q = '0;
			cur_q = '0;
			tmp_q = '0;
			fine_x_q = '0;
			toggle_q = 1'b0;
			oam_ptr = '0;
			foreach (oam_bytes[i]) oam_bytes[i] = '0;
			rbuf_q = '0;
			rd_pending_q = 1'b0;
			rd_palette_q = 1'b0;
			expected_results.delete();
			failures = 0;
			pending_results = 0;
		end else begin
			// a result always leaves after its beat was accepted, so retire before predicting
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: kind %0d", result_kind);
					failures++;
				end else begin
					want = expected_results.pop_front();
					check_field("result_kind", want.kind, result_kind);
					check_field("cpu_rdata", want.cpu_rdata, cpu_rdata);
					check_field("vram_addr", want.vram_addr, vram_addr);
					check_field("vram_wdata", want.vram_wdata, vram_wdata);
					check_field("control_bits", want.control, control_bits);
					check_field("mask_bits", want.mask, mask_bits);
					check_field("fine_scroll_x", want.fine_x, fine_scroll_x);
					check_field("temp_address", want.scroll_tmp, temp_address);
					check_field("current_address", want.cur_addr, current_address);
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(port_response(mode_t'(mode), reg_index, write_data,
					vram_rdata, event_t'(event_code)));
			pending_results = expected_results.size();
		end
	end

endmodule

### verif/testbench.sv
// Top of the register port testbench: clock, reset, stimulus and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import vcrp_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = '0;
	logic [2:0]  reg_index = '0;
	logic [7:0]  write_data = '0;
	logic [7:0]  vram_rdata = '0;
	logic [1:0]  event_code = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  cpu_rdata;
	logic [13:0] vram_addr;
	logic [7:0]  vram_wdata;
	logic [7:0]  control_bits;
	logic [7:0]  mask_bits;
	logic [2:0]  fine_scroll_x;
	logic [14:0] temp_address;
	logic [14:0] current_address;

	int failures;
	int pending_results;

	int send_idle_pct = 15;
	int recv_idle_pct = 77;
	int beats_sent = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;

	video_chip_register_port dut (.*);

	register_port_checker port_check (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver: random back-pressure, plus long hold-offs on request
	initial begin
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = 60;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_beat(mode_t md, logic [2:0] ri, logic [7:0] wd, logic [7:0] rd,
			event_t ev);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		reg_index <= ri;
		write_data <= wd;
		vram_rdata <= rd;
		event_code <= ev;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		beats_sent++;
	endtask

	// unused payload fields carry random values
	task automatic wr_reg(logic [2:0] ri, logic [7:0] wd);
		send_beat(MODE_WRITE, ri, wd, 8'($urandom), event_t'($urandom_range(3)));
	endtask

	task automatic rd_reg(logic [2:0] ri);
		send_beat(MODE_READ, ri, 8'($urandom), 8'($urandom), event_t'($urandom_range(3)));
	endtask

	task automatic vram_return(logic [7:0] rd);
		send_beat(MODE_RETURN, 3'($urandom), 8'($urandom), rd, event_t'($urandom_range(3)));
	endtask

	task automatic frame_event(event_t ev);
		send_beat(MODE_EVENT, 3'($urandom), 8'($urandom), 8'($urandom), ev);
	endtask

	task automatic noise_beat();
		send_beat(mode_t'($urandom_range(3)), 3'($urandom), 8'($urandom), 8'($urandom),
			event_t'($urandom_range(3)));
	endtask

	task automatic data_port_traffic(int count, int return_pct);
		repeat (count) begin
			if ($urandom_range(1))
				wr_reg(REG_DATA, 8'($urandom));
			else
				rd_reg(REG_DATA);
			if ($urandom_range(99) < return_pct)
				vram_return(8'($urandom));
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
	endtask

	task automatic random_access_burst();
		case ($urandom_range(9))
			0: noise_beat();
			1: begin
				if ($urandom_range(1)) rd_reg(REG_STATUS);
				// bias the high byte toward the palette page
				if ($urandom_range(1))
					wr_reg(REG_ADDR, {2'($urandom), 6'h3f});
				else
					wr_reg(REG_ADDR, 8'($urandom));
				wr_reg(REG_ADDR, 8'($urandom));
				data_port_traffic($urandom_range(1, 4), 70);
			end
			2: begin
				if ($urandom_range(1)) rd_reg(REG_STATUS);
				wr_reg(REG_SCROLL, 8'($urandom));
				wr_reg(REG_SCROLL, 8'($urandom));
			end
			3: wr_reg(REG_CTRL, 8'($urandom));
			4: wr_reg(REG_MASK, 8'($urandom));
			5: begin
				logic [7:0] base;
				base = $urandom_range(1) ? 8'($urandom_range(250, 255)) : 8'($urandom);
				wr_reg(REG_OAM_ADDR, base);
				repeat ($urandom_range(1, 6)) wr_reg(REG_OAM_DATA, 8'($urandom));
				wr_reg(REG_OAM_ADDR, base + 8'($urandom_range(0, 3)));
				rd_reg(REG_OAM_DATA);
			end
			6: begin
				repeat ($urandom_range(1, 3)) frame_event(event_t'($urandom_range(3)));
				rd_reg(REG_STATUS);
			end
			7: data_port_traffic($urandom_range(1, 3), 80);
			8: rd_reg(3'($urandom));
			default: vram_return(8'($urandom));
		endcase
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: flags, sprite memory wrap, register extremes, data port cases
		rd_reg(REG_STATUS);
		frame_event(EV_VBLANK);
		frame_event(EV_SPR_HIT);
		frame_event(EV_OVERFLOW);
		rd_reg(REG_STATUS);
		rd_reg(REG_STATUS);
		frame_event(EV_CLEAR);
		rd_reg(REG_OAM_DATA);
		wr_reg(REG_OAM_ADDR, 8'hff);
		wr_reg(REG_OAM_DATA, 8'hff);
		rd_reg(REG_OAM_DATA);
		wr_reg(REG_CTRL, 8'hff);
		wr_reg(REG_MASK, 8'hff);
		wr_reg(REG_STATUS, 8'hff);
		wr_reg(REG_SCROLL, 8'hff);
		wr_reg(REG_SCROLL, 8'h00);
		vram_return(8'haa);
		wr_reg(REG_ADDR, 8'hff);
		wr_reg(REG_ADDR, 8'hff);
		rd_reg(REG_DATA);
		vram_return(8'h12);
		rd_reg(REG_DATA);
		rd_reg(REG_DATA);
		vram_return(8'h55);
		wr_reg(REG_DATA, 8'h00);
		wr_reg(REG_CTRL, 8'h00);
		rd_reg(REG_CTRL);

		while (beats_sent < 130) random_access_burst();

		send_idle_pct = 77;
		recv_idle_pct = 15;
		while (beats_sent < 260) random_access_burst();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		// stall the output while the input keeps pushing, then let it all drain
		hold_requests++;
		repeat (12) noise_beat();
		wait_drained();

		// stride-32 walk from 0x3fe0 across bit 14
		rd_reg(REG_STATUS);
		wr_reg(REG_CTRL, 8'($urandom) | 8'h04);
		wr_reg(REG_ADDR, 8'h3f);
		wr_reg(REG_ADDR, 8'he0);
		data_port_traffic(6, 10);

		// stride-32 walk from 0x7fe0 around the 15-bit wrap; bit 14 comes from a scroll write
		rd_reg(REG_STATUS);
		wr_reg(REG_ADDR, 8'h3f);
		wr_reg(REG_SCROLL, 8'hff);
		wr_reg(REG_SCROLL, 8'($urandom));
		wr_reg(REG_ADDR, 8'he0);
		data_port_traffic(6, 10);

		while (beats_sent < 400) random_access_burst();

		wait_drained();
		repeat (8) @(negedge clk);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### files.f
hdl/vcrp_pkg.sv
hdl/vcrp_front.sv
hdl/vcrp_queue.sv
hdl/vcrp_back.sv
hdl/video_chip_register_port.sv
verif/register_port_checker.sv
verif/testbench.sv
